// ===== design/nogp_pkg.sv =====
// Package for the nearest-obstacle goal push-out block.
// Holds widths, register indexes and the sequencer state type; no dependencies.
`default_nettype none
package nogp_pkg;
    localparam int COORD_BITS_DEF = 24;
    localparam int CLR_BITS       = 20;
    localparam int CLR_RESET      = 2048;
    localparam int PADDR_BITS     = 4;

    localparam logic [PADDR_BITS-1:0] ADDR_GOAL_X    = 4'h0;
    localparam logic [PADDR_BITS-1:0] ADDR_GOAL_Y    = 4'h4;
    localparam logic [PADDR_BITS-1:0] ADDR_GOAL_Z    = 4'h8;
    localparam logic [PADDR_BITS-1:0] ADDR_CLEARANCE = 4'hC;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_COINCIDE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CMP,
        S_FINAL,
        S_SQRT,
        S_DIVSET,
        S_DIV,
        S_DIVEND,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== design/nogp_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Used for the point input and result output; no package dependency.
`default_nettype none
interface nogp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/nearest_obstacle_goal_pushout.sv =====
// Top level: streaming nearest-point search and goal push-out.
// Depends on nogp_pkg, nogp_if and nogp_regs.
//
//  channel   dir  handshake        payload
//  in_pt     in   valid/ready      point_x/y/z, point_valid, last_point
//  out_res   out  valid/ready      safe_x/y/z, moved, status
//  apb       in   psel/penable     goal_x/y/z, clearance
//
// A valid point passes through the accept, three squares through one shared multiplier,
// then a compare. The last item adds a final check and, on a push, a root
// (COORD_BITS+2 steps) and three restoring divides (one quotient bit a cycle,
// each with setup and writeback), then an output load.
// Reset clears the search state and the result valid flag; a finished result waits
// in the output load state only while the previous one is still untaken.
`default_nettype none
module nearest_obstacle_goal_pushout
    import nogp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    nogp_if.sink                    in_pt,
    nogp_if.source                  out_res,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [PADDR_BITS-1:0]   paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int DB = COORD_BITS + 1;          // difference width
    localparam int SB = 2*DB + 2;                // sum of squares width
    localparam int NB = DB + CLR_BITS + 1;       // 2*m*clr + root numerator
    localparam int CB = $clog2(NB + 1);
    localparam int PW = COORD_BITS + CLR_BITS + 2; // pushed coordinate width

    logic signed [COORD_BITS-1:0] goal_x, goal_y, goal_z;
    logic [CLR_BITS-1:0]          clr;

    nogp_regs #(.COORD_BITS(COORD_BITS)) u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_goal_x(goal_x), .o_goal_y(goal_y), .o_goal_z(goal_z), .o_clearance(clr)
    );

    t_state r_state, n_state;
    logic [1:0] r_ax;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic r_last;
    logic [SB-1:0] r_acc, r_bsq;
    logic signed [COORD_BITS-1:0] r_bx, r_by, r_bz;
    logic r_any;
    logic [SB-1:0] r_rem;
    logic [SB-1:0] r_root;
    logic [CB-1:0] r_cnt;
    logic [NB-1:0] r_num, r_q;
    logic [NB:0]   r_drem;
    logic signed [PW-1:0] r_res [3];
    logic r_fmoved;
    logic [1:0] r_fstat;
    logic r_ovalid;
    logic [COORD_BITS-1:0] r_ox, r_oy, r_oz;
    logic r_omoved;
    logic [1:0] r_ostat;

    // shared multiplier operand: difference on the current axis
    logic signed [COORD_BITS-1:0] g_sel, p_sel;
    logic signed [DB-1:0] diff;
    logic [DB-1:0] dmag;
    always_comb begin
        case (r_ax)
            2'd0:    begin g_sel = goal_x; p_sel = r_state == S_SQ ? r_px : r_bx; end
            2'd1:    begin g_sel = goal_y; p_sel = r_state == S_SQ ? r_py : r_by; end
            default: begin g_sel = goal_z; p_sel = r_state == S_SQ ? r_pz : r_bz; end
        endcase
        diff = DB'(g_sel) - DB'(p_sel);
        dmag = diff[DB-1] ? DB'(-diff) : DB'(diff);
    end
    logic [2*DB-1:0] sq;
    assign sq = dmag * dmag;

    // root step (bit-pair restoring)
    logic [SB-1:0] rbit, rtry;
    assign rbit = SB'(1) << (2*r_cnt);
    assign rtry = r_root + rbit;

    logic [CLR_BITS+DB:0] prod;
    assign prod = (CLR_BITS+DB+1)'(dmag) * (CLR_BITS+DB+1)'(clr);

    logic [NB:0] dtry;
    logic [NB:0] dshift;
    assign dshift = {r_drem[NB-1:0], r_num[NB-1]};
    assign dtry   = dshift - (NB+1)'({r_root, 1'b0});

    logic signed [PW-1:0] lim_hi, lim_lo, pushed;
    assign lim_hi = PW'({1'b0, {(COORD_BITS-1){1'b1}}});
    assign lim_lo = -lim_hi - 1;
    assign pushed = PW'(p_sel) + (diff[DB-1] ? -PW'(r_q) : PW'(r_q));

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [PW-1:0] v,
                                                 input logic signed [PW-1:0] hi,
                                                 input logic signed [PW-1:0] lo);
        if (v > hi) return hi[COORD_BITS-1:0];
        if (v < lo) return lo[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    logic [2*CLR_BITS-1:0] clr_sq;
    assign clr_sq = clr * clr;

    logic near;
    assign near = r_bsq < SB'(clr_sq);

    // load the result register once the previous result has left it
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || out_res.ready);

    assign in_pt.ready = (r_state == S_IDLE);
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_pt.valid)
                          n_state = in_pt.data.point_valid ? S_SQ
                                  : (in_pt.data.last_point ? S_FINAL : S_IDLE);
            S_SQ:     if (r_ax == 2'd2) n_state = S_CMP;
            S_CMP:    n_state = r_last ? S_FINAL : S_IDLE;
            S_FINAL:  n_state = (r_any && r_bsq != '0 && near) ? S_SQRT : S_OUT;
            S_SQRT:   if (r_cnt == '0) n_state = S_DIVSET;
            S_DIVSET: n_state = S_DIV;
            S_DIV:    if (r_cnt == '0) n_state = S_DIVEND;
            S_DIVEND: n_state = (r_ax == 2'd2) ? S_OUT : S_DIVSET;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_any    <= 1'b0;
            r_bsq    <= '1;
            r_bx <= '0; r_by <= '0; r_bz <= '0;
            r_ax     <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ovalid <= 1'b1;
            else if (out_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_pt.valid) begin
                    r_px <= in_pt.data.point_x;
                    r_py <= in_pt.data.point_y;
                    r_pz <= in_pt.data.point_z;
                    r_last <= in_pt.data.last_point;
                    r_ax   <= '0;
                    r_acc  <= '0;
                end
                S_SQ: begin
                    r_acc <= r_acc + SB'(sq);
                    r_ax  <= r_ax + 2'd1;
                end
                S_CMP: if (!r_any || r_acc < r_bsq) begin
                    r_bsq <= r_acc; r_any <= 1'b1;
                    r_bx <= r_px; r_by <= r_py; r_bz <= r_pz;
                end
                S_FINAL: begin
                    r_res[0] <= PW'(goal_x);
                    r_res[1] <= PW'(goal_y);
                    r_res[2] <= PW'(goal_z);
                    r_fstat  <= !r_any ? STATUS_EMPTY
                              : (r_bsq == '0 ? STATUS_COINCIDE : STATUS_OK);
                    r_fmoved <= r_any && r_bsq != '0 && near;
                    r_rem    <= r_bsq;
                    r_root   <= '0;
                    r_cnt    <= CB'((SB/2) - 1);
                    r_ax     <= '0;
                end
                S_SQRT: begin
                    if (r_rem >= rtry) begin
                        r_rem  <= r_rem - rtry;
                        r_root <= (r_root >> 1) + rbit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                S_DIVSET: begin
                    r_num  <= NB'({prod, 1'b0}) + NB'(r_root);
                    r_drem <= '0;
                    r_q    <= '0;
                    r_cnt  <= CB'(NB - 1);
                end
                S_DIV: begin
                    // restoring divide by 2*root, one quotient bit a cycle
                    if (!dtry[NB]) begin
                        r_drem <= dtry;
                        r_q    <= {r_q[NB-2:0], 1'b1};
                    end else begin
                        r_drem <= dshift;
                        r_q    <= {r_q[NB-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 1'b1;
                end
                S_DIVEND: begin
                    r_res[r_ax] <= pushed;
                    r_ax <= r_ax + 2'd1;
                end
                S_OUT: if (out_load) begin
                    r_ox <= sat(r_res[0], lim_hi, lim_lo);
                    r_oy <= sat(r_res[1], lim_hi, lim_lo);
                    r_oz <= sat(r_res[2], lim_hi, lim_lo);
                    r_omoved <= r_fmoved;
                    r_ostat  <= r_fstat;
                    r_any <= 1'b0;
                    r_bsq <= '1;
                    r_bx <= '0; r_by <= '0; r_bz <= '0;
                end
                default: ;
            endcase
        end
    end

    assign out_res.valid        = r_ovalid;
    assign out_res.data.safe_x  = r_ox;
    assign out_res.data.safe_y  = r_oy;
    assign out_res.data.safe_z  = r_oz;
    assign out_res.data.moved   = r_omoved;
    assign out_res.data.status  = r_ostat;
endmodule
`default_nettype wire

// ===== design/nogp_regs.sv =====
// APB register file: goal coordinates and clearance.
// Depends on nogp_pkg.
`default_nettype none
module nogp_regs
    import nogp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire        [PADDR_BITS-1:0]   paddr,
    input  wire        [31:0]             pwdata,
    output logic       [31:0]             prdata,
    output logic                          pready,
    output logic signed [COORD_BITS-1:0]  o_goal_x,
    output logic signed [COORD_BITS-1:0]  o_goal_y,
    output logic signed [COORD_BITS-1:0]  o_goal_z,
    output logic       [CLR_BITS-1:0]     o_clearance
);
    logic signed [COORD_BITS-1:0] r_gx, r_gy, r_gz;
    logic [CLR_BITS-1:0]          r_clr;
    logic                         wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx  <= '0;
            r_gy  <= '0;
            r_gz  <= '0;
            r_clr <= CLR_BITS'(CLR_RESET);
        end else if (wr) begin
            case (paddr)
                ADDR_GOAL_X:    r_gx  <= pwdata[COORD_BITS-1:0];
                ADDR_GOAL_Y:    r_gy  <= pwdata[COORD_BITS-1:0];
                ADDR_GOAL_Z:    r_gz  <= pwdata[COORD_BITS-1:0];
                ADDR_CLEARANCE: r_clr <= pwdata[CLR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_GOAL_X:    prdata = 32'(r_gx);
            ADDR_GOAL_Y:    prdata = 32'(r_gy);
            ADDR_GOAL_Z:    prdata = 32'(r_gz);
            ADDR_CLEARANCE: prdata = 32'(r_clr);
            default:        prdata = '0;
        endcase
    end

    assign o_goal_x    = r_gx;
    assign o_goal_y    = r_gy;
    assign o_goal_z    = r_gz;
    assign o_clearance = r_clr;
endmodule
`default_nettype wire
